FILE: hw/rtl/triangle_face_normal_top_defines.svh
// assertion helpers shared by the checker
`ifndef TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH

// checked only outside reset
`define TFN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define TFN_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/tfn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;
   localparam int COORD_WIDTH  = 24;
   localparam int NORMAL_WIDTH = 16;

   // edge, product and cross widths
   localparam int EW  = COORD_WIDTH + 1;
   localparam int PRW = 2 * EW;
   localparam int CRW = PRW + 1;
   localparam int MW  = CRW - 1;
   // split of the magnitude for squaring
   localparam int MLO = MW / 2;
   localparam int MHI = MW - MLO;
   localparam int SQW = 2 * MW;
   localparam int SW  = SQW + 2;
   // quotient bits, running products
   localparam int QW  = NORMAL_WIDTH - 1;
   localparam int QSW = SW + QW;
   localparam int PW  = SW + 2 * QW + 1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   typedef logic signed [COORD_WIDTH-1:0]  coord_type;
   typedef logic signed [NORMAL_WIDTH-1:0] normal_type;
   typedef logic [MW-1:0]                  mag_type;

   typedef struct packed {
      logic [2:0][MW-1:0] mag;
      logic [2:0]         neg;
      logic               last;
   } item_type;
endpackage
`default_nettype wire

FILE: hw/rtl/tfn_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface tfn_req_if;
   logic              valid;
   logic              ready;
   tfn_pkg::coord_type ax;
   tfn_pkg::coord_type ay;
   tfn_pkg::coord_type az;
   tfn_pkg::coord_type bx;
   tfn_pkg::coord_type by_coord;
   tfn_pkg::coord_type bz;
   tfn_pkg::coord_type cx;
   tfn_pkg::coord_type cy;
   tfn_pkg::coord_type cz;
   logic              in_last;
   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, in_last,
                   input ready);
   modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, in_last,
                 output ready);
endinterface

interface tfn_rsp_if;
   logic               valid;
   logic               ready;
   tfn_pkg::normal_type normal_x;
   tfn_pkg::normal_type normal_y;
   tfn_pkg::normal_type normal_z;
   logic               degenerate;
   logic               out_last;
   modport source (output valid, normal_x, normal_y, normal_z, degenerate, out_last,
                   input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, degenerate, out_last,
                 output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tfn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tfn_front (
   input  wire logic          clock,
   input  wire logic          reset,
   tfn_req_if.sink            req,
   input  wire logic          fifo_full,
   output logic               push_valid,
   output tfn_pkg::item_type  push_data
);
   localparam int EW  = tfn_pkg::EW;
   localparam int PRW = tfn_pkg::PRW;
   localparam int CRW = tfn_pkg::CRW;
   localparam int MW  = tfn_pkg::MW;

   logic en;
   logic v1_ff, v2_ff, v3_ff;
   logic l1_ff, l2_ff;
   logic signed [EW-1:0]  e1_in [3];
   logic signed [EW-1:0]  e2_in [3];
   logic signed [EW-1:0]  e1_ff [3];
   logic signed [EW-1:0]  e2_ff [3];
   logic signed [PRW-1:0] pr_in [6];
   logic signed [PRW-1:0] pr_ff [6];
   logic signed [CRW-1:0] cr [3];
   tfn_pkg::item_type     item_in, item_ff;

   assign en         = !v3_ff || !fifo_full;
   assign req.ready  = en;
   assign push_valid = v3_ff && !fifo_full;
   assign push_data  = item_ff;

   always_comb begin
      e1_in[0] = EW'(req.bx) - EW'(req.ax);
      e1_in[1] = EW'(req.by_coord) - EW'(req.ay);
      e1_in[2] = EW'(req.bz) - EW'(req.az);
      e2_in[0] = EW'(req.cx) - EW'(req.ax);
      e2_in[1] = EW'(req.cy) - EW'(req.ay);
      e2_in[2] = EW'(req.cz) - EW'(req.az);
   end

   always_comb begin
      pr_in[0] = PRW'(e1_ff[1]) * PRW'(e2_ff[2]);
      pr_in[1] = PRW'(e1_ff[2]) * PRW'(e2_ff[1]);
      pr_in[2] = PRW'(e1_ff[2]) * PRW'(e2_ff[0]);
      pr_in[3] = PRW'(e1_ff[0]) * PRW'(e2_ff[2]);
      pr_in[4] = PRW'(e1_ff[0]) * PRW'(e2_ff[1]);
      pr_in[5] = PRW'(e1_ff[1]) * PRW'(e2_ff[0]);
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cr[c] = CRW'(pr_ff[2*c]) - CRW'(pr_ff[2*c+1]);
         item_in.neg[c] = cr[c][CRW-1];
         item_in.mag[c] = MW'(cr[c][CRW-1] ? -cr[c] : cr[c]);
      end
      item_in.last = l2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff   <= e1_in;
         e2_ff   <= e2_in;
         l1_ff   <= req.in_last;
         pr_ff   <= pr_in;
         l2_ff   <= l1_ff;
         item_ff <= item_in;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tfn_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module tfn_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tfn_pkg::item_type  push_data,
   input  wire logic               pop,
   output tfn_pkg::item_type       pop_data,
   output logic                    full,
   output logic                    not_empty
);
   localparam int AW = tfn_pkg::FIFO_AW;

   tfn_pkg::item_type mem_ff [tfn_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   count_ff, count_in;

   assign full      = count_ff == (AW+1)'(tfn_pkg::FIFO_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tfn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tfn_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tfn_pkg::item_type  pop_data,
   input  wire logic               not_empty,
   output logic                    pop,
   tfn_rsp_if.source               rsp
);
   localparam int MW  = tfn_pkg::MW;
   localparam int MLO = tfn_pkg::MLO;
   localparam int MHI = tfn_pkg::MHI;
   localparam int SQW = tfn_pkg::SQW;
   localparam int SW  = tfn_pkg::SW;
   localparam int QW  = tfn_pkg::QW;
   localparam int QSW = tfn_pkg::QSW;
   localparam int PW  = tfn_pkg::PW;
   localparam int NW  = tfn_pkg::NORMAL_WIDTH;

   typedef struct packed {
      logic [2:0] neg;
      logic       last;
      logic       deg;
   } side_type;

   logic en;
   logic vb1_ff, vb2_ff, vout_ff;
   logic vs_ff [QW+1];

   // partial squares
   logic [2*MHI-1:0]     hh_ff [3];
   logic [MHI+MLO-1:0]   hl_ff [3];
   logic [2*MLO-1:0]     ll_ff [3];
   side_type             sb1_ff, sb2_ff;
   logic [SQW-1:0]       m2_in [3];
   logic [SQW-1:0]       m2_ff [3];

   // restoring search, one quotient bit per stage
   logic [PW-1:0]  p_ff  [QW+1][3];
   logic [QSW-1:0] qs_ff [QW+1][3];
   logic [QW-1:0]  q_ff  [QW+1][3];
   logic [PW-1:0]  t_ff  [QW+1][3];
   logic [SW-1:0]  s_ff  [QW+1];
   side_type       sd_ff [QW+1];

   logic [SW-1:0]  s_in;
   tfn_pkg::normal_type nrm_in [3];
   tfn_pkg::normal_type nrm_ff [3];
   logic           deg_ff, last_ff;

   assign en  = !vout_ff || rsp.ready;
   assign pop = en && not_empty;

   assign rsp.valid      = vout_ff;
   assign rsp.normal_x   = nrm_ff[0];
   assign rsp.normal_y   = nrm_ff[1];
   assign rsp.normal_z   = nrm_ff[2];
   assign rsp.degenerate = deg_ff;
   assign rsp.out_last   = last_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         m2_in[c] = (SQW'(hh_ff[c]) << (2*MLO)) + (SQW'(hl_ff[c]) << (MLO+1))
                  + SQW'(ll_ff[c]);
      end
      s_in = SW'(m2_ff[0]) + SW'(m2_ff[1]) + SW'(m2_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            hh_ff[c] <= (2*MHI)'(pop_data.mag[c][MW-1:MLO]) *
                        (2*MHI)'(pop_data.mag[c][MW-1:MLO]);
            hl_ff[c] <= (MHI+MLO)'(pop_data.mag[c][MW-1:MLO]) *
                        (MHI+MLO)'(pop_data.mag[c][MLO-1:0]);
            ll_ff[c] <= (2*MLO)'(pop_data.mag[c][MLO-1:0]) *
                        (2*MLO)'(pop_data.mag[c][MLO-1:0]);
         end
         sb1_ff.neg  <= pop_data.neg;
         sb1_ff.last <= pop_data.last;
         sb1_ff.deg  <= (pop_data.mag[0] == '0) && (pop_data.mag[1] == '0) &&
                        (pop_data.mag[2] == '0);
         m2_ff  <= m2_in;
         sb2_ff <= sb1_ff;
         s_ff[0]  <= s_in;
         sd_ff[0] <= sb2_ff;
         for (int c = 0; c < 3; c++) begin
            t_ff[0][c]  <= PW'(m2_ff[c]) << (2*QW);
            p_ff[0][c]  <= '0;
            qs_ff[0][c] <= '0;
            q_ff[0][c]  <= '0;
         end
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_bit
      localparam int Bit = QW - 1 - k;
      for (genvar c = 0; c < 3; c++) begin : g_comp
         logic [PW-1:0]  test;
         logic [PW-1:0]  p_in;
         logic [QSW-1:0] qs_in;
         logic [QW-1:0]  q_in;
         // (q + 2^bit)^2 * s from the running q^2*s and q*s
         assign test = p_ff[k][c] + (PW'(qs_ff[k][c]) << (Bit+1))
                     + (PW'(s_ff[k]) << (2*Bit));
         always_comb begin
            p_in  = p_ff[k][c];
            qs_in = qs_ff[k][c];
            q_in  = q_ff[k][c];
            if (test <= t_ff[k][c]) begin
               p_in  = test;
               qs_in = qs_ff[k][c] + (QSW'(s_ff[k]) << Bit);
               q_in  = q_ff[k][c] | (QW'(1) << Bit);
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               p_ff[k+1][c]  <= p_in;
               qs_ff[k+1][c] <= qs_in;
               q_ff[k+1][c]  <= q_in;
               t_ff[k+1][c]  <= t_ff[k][c];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k+1]  <= s_ff[k];
            sd_ff[k+1] <= sd_ff[k];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (sd_ff[QW].deg) nrm_in[c] = '0;
         else if (sd_ff[QW].neg[c]) nrm_in[c] = -NW'(q_ff[QW][c]);
         else nrm_in[c] = NW'(q_ff[QW][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nrm_ff  <= nrm_in;
         deg_ff  <= sd_ff[QW].deg;
         last_ff <= sd_ff[QW].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb1_ff  <= 1'b0;
         vb2_ff  <= 1'b0;
         vout_ff <= 1'b0;
         for (int k = 0; k <= QW; k++) vs_ff[k] <= 1'b0;
      end else if (en) begin
         vb1_ff   <= not_empty;
         vb2_ff   <= vb1_ff;
         vs_ff[0] <= vb2_ff;
         for (int k = 0; k < QW; k++) vs_ff[k+1] <= vs_ff[k];
         vout_ff  <= vs_ff[QW];
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/triangle_face_normal_top.sv
// triangle face normal
// req channel: one beat per triangle, vertices a, b, c in signed q12.12 plus in_last.
// rsp channel: one beat per triangle, unit normal in signed q1.15 truncated toward
// zero and held within +-32767, degenerate set (normal zero) when the cross product
// is zero, out_last copied from in_last.
// throughput: one triangle per cycle while rsp_ready stays high.
// path from req beat to rsp beat at the default widths: three front
// stages (edges, products, cross and magnitude), then the queue, two squaring stages,
// one sum stage, one stage per quotient bit (15) and the output register.
// the front stalls only when the four-entry queue is full; the back pipeline and
// output register hold while a rsp beat waits, and the queue absorbs what is in
// flight, so req_ready does not depend on rsp_ready in the same cycle.
// reset (synchronous) empties the queue and drops every beat in flight.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal_top (
   input  wire logic clock,
   input  wire logic reset,
   tfn_req_if.sink   req,
   tfn_rsp_if.source rsp
);
   logic              push_valid, fifo_full, pop, not_empty;
   tfn_pkg::item_type push_data, pop_data;

   tfn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .fifo_full  (fifo_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   tfn_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .not_empty (not_empty)
   );

   tfn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp       (rsp)
   );
endmodule
`default_nettype wire

FILE: hw/rtl/tfn_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_face_normal_top_defines.svh"
module tfn_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire tfn_pkg::normal_type rsp_normal_x,
   input wire tfn_pkg::normal_type rsp_normal_y,
   input wire tfn_pkg::normal_type rsp_normal_z,
   input wire logic                rsp_degenerate
);
   localparam int NW = tfn_pkg::NORMAL_WIDTH;
   localparam tfn_pkg::normal_type MinCode = {1'b1, {(NW-1){1'b0}}};

   `TFN_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid, "rsp beat right after reset")
   `TFN_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x) && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_degenerate), "stalled rsp beat changed")
   `TFN_ASSERT(a_deg_zero, rsp_valid && rsp_degenerate |-> rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0, "degenerate normal not zero")
   `TFN_ASSERT(a_nondeg_range, rsp_valid && !rsp_degenerate |-> (rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0) && rsp_normal_x != MinCode && rsp_normal_y != MinCode && rsp_normal_z != MinCode, "normal out of range")
endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_normal_x   (rsp.normal_x),
   .rsp_normal_y   (rsp.normal_y),
   .rsp_normal_z   (rsp.normal_z),
   .rsp_degenerate (rsp.degenerate)
);
`default_nettype wire
